[rtl/core/nrb_pkg.sv]
package nrb_pkg;

  typedef logic signed [31:0] q_t;

  // packed complex value: real part in the upper half, as in the config registers
  typedef struct packed {
    q_t re;
    q_t im;
  } cplx_t;

  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic ov;
    q_t   val;
  } sat_t;

  typedef struct packed {
    logic done;
    logic ov;
  } div_stat_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_FIN  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_NEAR = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  // register indexes on the config port
  localparam logic [2:0] REG_COEF_0     = 3'd0;
  localparam logic [2:0] REG_COEF_1     = 3'd1;
  localparam logic [2:0] REG_COEF_2     = 3'd2;
  localparam logic [2:0] REG_COEF_3     = 3'd3;
  localparam logic [2:0] REG_ROOT_A     = 3'd4;
  localparam logic [2:0] REG_ROOT_B     = 3'd5;
  localparam logic [2:0] REG_ROOT_C     = 3'd6;
  localparam logic [2:0] REG_STEP_LIMIT = 3'd7;

  localparam logic [63:0] COEF_0_RST     = 64'hF000_0000_0000_0000;
  localparam logic [63:0] COEF_3_RST     = 64'h1000_0000_0000_0000;
  localparam logic [15:0] STEP_LIMIT_RST = 16'd30;

  // micro-op sequence of one newton step
  localparam logic [2:0] OP_P0  = 3'd0;  // c3*z + c2
  localparam logic [2:0] OP_P1  = 3'd1;  // t*z + c1
  localparam logic [2:0] OP_P2  = 3'd2;  // t*z + c0 -> p
  localparam logic [2:0] OP_D0  = 3'd3;  // d2*z + d1
  localparam logic [2:0] OP_D1  = 3'd4;  // t*z + c1 -> p'
  localparam logic [2:0] OP_DEN = 3'd5;  // |p'|^2
  localparam logic [2:0] OP_NUM = 3'd6;  // p * conj(p')

  localparam int unsigned DIV_STEPS = 31;

  localparam wide_t Q_MAX = 66'sd2147483647;
  localparam wide_t Q_MIN = -66'sd2147483648;

  function automatic wide_t sx66(input q_t v);
    sx66 = {{34{v[31]}}, v};
  endfunction

  function automatic sat_t sat66(input wide_t v);
    sat_t r;
    if (v > Q_MAX) begin
      r.ov  = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN) begin
      r.ov  = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.ov  = 1'b0;
      r.val = v[31:0];
    end
    sat66 = r;
  endfunction

endpackage

[rtl/core/newton_root_basin_iterator_core.sv]
// newton iteration on a complex cubic, one start point per input beat
//
// config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   always ready, write only while the core is idle. indexes 0..3 are the
//   coefficients, 4..6 the roots a, b, c, 7 the step limit
// input channel: in_valid_i/in_ready_o carrying the start point (Q4.28)
// output channel: out_valid_o/out_ready_i carrying iterations, converged
//   and root_index; one result beat per input beat
//
// per newton step: seven complex multiply-adds on the one shared 33x33
//   multiplier, two radix-2 divisions, an update and three root checks
// throughput: one point at a time, in_ready_o is high only while idle
// reset: control and config registers return to their reset values, no beat is pending
// stall: a finished result sits in the output register; a new point is
//   taken meanwhile, and a second result waits until the first is taken
module newton_root_basin_iterator_core #(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned NEAR_TOL  = 2684
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] start_real_i,
  input  logic [31:0] start_imag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] iterations_o,
  output logic        converged_o,
  output logic [1:0]  root_index_o
);

  // config registers
  nrb_pkg::cplx_t coef_q [4];
  nrb_pkg::cplx_t root_q [3];
  logic [15:0]    step_limit_q;

  nrb_pkg::state_e state_q, state_d;

  // working values
  nrb_pkg::cplx_t z_q, z_d, t_q, t_d, p_q, p_d, d_q, d_d, d2_q, d2_d, d1_q, d1_d;
  logic [63:0]        den_q, den_d;
  logic signed [63:0] nre_q, nre_d, nim_q, nim_d;
  nrb_pkg::q_t        qre_q, qre_d, qim_q, qim_d;
  nrb_pkg::wide_t     acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [63:0]        sq_q, sq_d;

  // sequencer counters
  logic [2:0]  op_q, op_d;
  logic [2:0]  k_q, k_d;
  logic [1:0]  rk_q, rk_d;
  logic [1:0]  nk_q, nk_d;
  logic [15:0] it_q, it_d;
  logic        div_im_q, div_im_d;
  logic        div_go_q, div_go_d;

  // pending and registered result
  logic [15:0] fin_it_q, fin_it_d;
  logic        fin_conv_q, fin_conv_d;
  logic [1:0]  fin_idx_q, fin_idx_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] res_it_q, res_it_d;
  logic        res_conv_q, res_conv_d;
  logic [1:0]  res_idx_q, res_idx_d;

  // shared units
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod;
  nrb_pkg::div_stat_t  div_stat;
  nrb_pkg::q_t         div_q;

  nrb_pkg::cplx_t opa, opb, opc;
  logic           conj;
  nrb_pkg::wide_t term;
  nrb_pkg::sat_t  s_re, s_im, a_re, a_im, u_re, u_im, x2_re, x2_im, x3_re, x3_im;
  nrb_pkg::cplx_t rsel;
  logic signed [32:0] dr, di;
  logic [32:0]        mr, mi;
  logic               far;
  logic [63:0]        sq_sum;
  logic               hit;

  nrb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  nrb_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_im_q ? nim_q : nre_q),
    .den_i   (den_q),
    .stat_o  (div_stat),
    .quot_o  (div_q)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0]    <= nrb_pkg::COEF_0_RST;
      coef_q[1]    <= '0;
      coef_q[2]    <= '0;
      coef_q[3]    <= nrb_pkg::COEF_3_RST;
      root_q[0]    <= '0;
      root_q[1]    <= '0;
      root_q[2]    <= '0;
      step_limit_q <= nrb_pkg::STEP_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nrb_pkg::REG_COEF_0:     coef_q[0]    <= cfg_data_i;
        nrb_pkg::REG_COEF_1:     coef_q[1]    <= cfg_data_i;
        nrb_pkg::REG_COEF_2:     coef_q[2]    <= cfg_data_i;
        nrb_pkg::REG_COEF_3:     coef_q[3]    <= cfg_data_i;
        nrb_pkg::REG_ROOT_A:     root_q[0]    <= cfg_data_i;
        nrb_pkg::REG_ROOT_B:     root_q[1]    <= cfg_data_i;
        nrb_pkg::REG_ROOT_C:     root_q[2]    <= cfg_data_i;
        nrb_pkg::REG_STEP_LIMIT: step_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == nrb_pkg::S_IDLE);

  // operand select for the complex multiply-add
  always_comb begin
    opb  = z_q;
    opc  = '0;
    conj = 1'b0;
    case (op_q)
      nrb_pkg::OP_P0:  begin opa = coef_q[3]; opc = coef_q[2]; end
      nrb_pkg::OP_P1:  begin opa = t_q;       opc = coef_q[1]; end
      nrb_pkg::OP_P2:  begin opa = t_q;       opc = coef_q[0]; end
      nrb_pkg::OP_D0:  begin opa = d2_q;      opc = d1_q;      end
      nrb_pkg::OP_D1:  begin opa = t_q;       opc = coef_q[1]; end
      nrb_pkg::OP_DEN: begin opa = d_q; opb = d_q; conj = 1'b1; end
      nrb_pkg::OP_NUM: begin opa = p_q; opb = d_q; conj = 1'b1; end
      default:         begin opa = '0; end
    endcase
  end

  // root distance, checked against one root at a time
  always_comb begin
    rsel   = root_q[rk_q];
    dr     = {z_q.re[31], z_q.re} - {rsel.re[31], rsel.re};
    di     = {z_q.im[31], z_q.im} - {rsel.im[31], rsel.im};
    mr     = dr[32] ? 33'(-dr) : 33'(dr);
    mi     = di[32] ? 33'(-di) : 33'(di);
    far    = (mr[32:31] != 2'b00) || (mi[32:31] != 2'b00);
    sq_sum = sq_q + prod[63:0];
    hit    = !far && ((sq_sum >> FRAC_BITS) < 64'(NEAR_TOL));
  end

  // multiplier operands
  always_comb begin
    if (state_q == nrb_pkg::S_NEAR) begin
      mul_a = (nk_q == 2'd0) ? $signed(mr) : $signed(mi);
      mul_b = mul_a;
    end else begin
      case (k_q[1:0])
        2'd0:    begin mul_a = {opa.re[31], opa.re}; mul_b = {opb.re[31], opb.re}; end
        2'd1:    begin mul_a = {opa.im[31], opa.im}; mul_b = {opb.im[31], opb.im}; end
        2'd2:    begin mul_a = {opa.re[31], opa.re}; mul_b = {opb.im[31], opb.im}; end
        default: begin mul_a = {opa.im[31], opa.im}; mul_b = {opb.re[31], opb.re}; end
      endcase
    end
  end

  // saturating helpers for the finish, prep and update steps
  always_comb begin
    term  = conj ? (prod >>> 2) : (prod >>> FRAC_BITS);
    s_re  = nrb_pkg::sat66(acc_re_q);
    s_im  = nrb_pkg::sat66(acc_im_q);
    a_re  = nrb_pkg::sat66(nrb_pkg::sx66(s_re.val) + nrb_pkg::sx66(opc.re));
    a_im  = nrb_pkg::sat66(nrb_pkg::sx66(s_im.val) + nrb_pkg::sx66(opc.im));
    u_re  = nrb_pkg::sat66(nrb_pkg::sx66(z_q.re) - nrb_pkg::sx66(qre_q));
    u_im  = nrb_pkg::sat66(nrb_pkg::sx66(z_q.im) - nrb_pkg::sx66(qim_q));
    x3_re = nrb_pkg::sat66(nrb_pkg::sx66(coef_q[3].re) * 66'sd3);
    x3_im = nrb_pkg::sat66(nrb_pkg::sx66(coef_q[3].im) * 66'sd3);
    x2_re = nrb_pkg::sat66(nrb_pkg::sx66(coef_q[2].re) <<< 1);
    x2_im = nrb_pkg::sat66(nrb_pkg::sx66(coef_q[2].im) <<< 1);
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    z_d = z_q; t_d = t_q; p_d = p_q; d_d = d_q; d2_d = d2_q; d1_d = d1_q;
    den_d      = den_q;
    nre_d      = nre_q;
    nim_d      = nim_q;
    qre_d      = qre_q;
    qim_d      = qim_q;
    acc_re_d   = acc_re_q;
    acc_im_d   = acc_im_q;
    sq_d       = sq_q;
    op_d       = op_q;
    k_d        = k_q;
    rk_d       = rk_q;
    nk_d       = nk_q;
    it_d       = it_q;
    div_im_d   = div_im_q;
    div_go_d   = 1'b0;
    fin_it_d   = fin_it_q;
    fin_conv_d = fin_conv_q;
    fin_idx_d  = fin_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_it_d   = res_it_q;
    res_conv_d = res_conv_q;
    res_idx_d  = res_idx_q;

    case (state_q)
      nrb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          z_d     = {start_real_i, start_imag_i};
          state_d = nrb_pkg::S_PREP;
        end
      end

      nrb_pkg::S_PREP: begin
        d2_d       = {x3_re.val, x3_im.val};
        d1_d       = {x2_re.val, x2_im.val};
        it_d       = '0;
        op_d       = nrb_pkg::OP_P0;
        k_d        = '0;
        fin_it_d   = step_limit_q;
        fin_conv_d = 1'b0;
        fin_idx_d  = '0;
        // derivative coefficient overflow or a zero limit: no step at all
        if (x3_re.ov || x3_im.ov || x2_re.ov || x2_im.ov || step_limit_q == 16'd0) begin
          state_d = nrb_pkg::S_DONE;
        end else begin
          state_d = nrb_pkg::S_MUL;
        end
      end

      nrb_pkg::S_MUL: begin
        // four partial products, each accumulated the cycle after issue
        case (k_q)
          3'd0: begin acc_re_d = '0; acc_im_d = '0; end
          3'd1: acc_re_d = acc_re_q + term;
          3'd2: acc_re_d = conj ? acc_re_q + term : acc_re_q - term;
          3'd3: acc_im_d = conj ? acc_im_q - term : acc_im_q + term;
          default: acc_im_d = acc_im_q + term;
        endcase
        if (k_q == 3'd4) begin
          k_d     = '0;
          state_d = nrb_pkg::S_FIN;
        end else begin
          k_d = k_q + 3'd1;
        end
      end

      nrb_pkg::S_FIN: begin
        op_d    = op_q + 3'd1;
        state_d = nrb_pkg::S_MUL;
        case (op_q)
          nrb_pkg::OP_DEN: begin
            den_d = acc_re_q[63:0];
            if (acc_re_q == '0) state_d = nrb_pkg::S_DONE;
          end
          nrb_pkg::OP_NUM: begin
            nre_d    = acc_re_q[63:0];
            nim_d    = acc_im_q[63:0];
            div_im_d = 1'b0;
            div_go_d = 1'b1;
            state_d  = nrb_pkg::S_DIV;
          end
          default: begin
            if (s_re.ov || s_im.ov || a_re.ov || a_im.ov) begin
              state_d = nrb_pkg::S_DONE;
            end else if (op_q == nrb_pkg::OP_P2) begin
              p_d = {a_re.val, a_im.val};
            end else if (op_q == nrb_pkg::OP_D1) begin
              d_d = {a_re.val, a_im.val};
            end else begin
              t_d = {a_re.val, a_im.val};
            end
          end
        endcase
      end

      nrb_pkg::S_DIV: begin
        if (div_stat.done) begin
          if (div_stat.ov) begin
            state_d = nrb_pkg::S_DONE;
          end else if (!div_im_q) begin
            qre_d    = div_q;
            div_im_d = 1'b1;
            div_go_d = 1'b1;
          end else begin
            qim_d   = div_q;
            state_d = nrb_pkg::S_UPD;
          end
        end
      end

      nrb_pkg::S_UPD: begin
        rk_d = '0;
        nk_d = '0;
        if (u_re.ov || u_im.ov) begin
          state_d = nrb_pkg::S_DONE;
        end else begin
          z_d     = {u_re.val, u_im.val};
          state_d = nrb_pkg::S_NEAR;
        end
      end

      nrb_pkg::S_NEAR: begin
        // issue mr^2, then mi^2, then sum and compare
        case (nk_q)
          2'd0: nk_d = 2'd1;
          2'd1: begin
            sq_d = prod[63:0];
            nk_d = 2'd2;
          end
          default: begin
            nk_d = '0;
            if (hit) begin
              fin_it_d   = it_q;
              fin_conv_d = 1'b1;
              fin_idx_d  = rk_q;
              state_d    = nrb_pkg::S_DONE;
            end else if (rk_q == 2'd2) begin
              if (it_q == step_limit_q - 16'd1) begin
                state_d = nrb_pkg::S_DONE;
              end else begin
                it_d    = it_q + 16'd1;
                op_d    = nrb_pkg::OP_P0;
                k_d     = '0;
                state_d = nrb_pkg::S_MUL;
              end
            end else begin
              rk_d = rk_q + 2'd1;
            end
          end
        endcase
      end

      nrb_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_it_d    = fin_it_q;
          res_conv_d  = fin_conv_q;
          res_idx_d   = fin_idx_q;
          state_d     = nrb_pkg::S_IDLE;
        end
      end

      default: state_d = nrb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nrb_pkg::S_IDLE;
      op_q        <= '0;
      k_q         <= '0;
      rk_q        <= '0;
      nk_q        <= '0;
      it_q        <= '0;
      div_im_q    <= 1'b0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      rk_q        <= rk_d;
      nk_q        <= nk_d;
      it_q        <= it_d;
      div_im_q    <= div_im_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q        <= z_d;
    t_q        <= t_d;
    p_q        <= p_d;
    d_q        <= d_d;
    d2_q       <= d2_d;
    d1_q       <= d1_d;
    den_q      <= den_d;
    nre_q      <= nre_d;
    nim_q      <= nim_d;
    qre_q      <= qre_d;
    qim_q      <= qim_d;
    acc_re_q   <= acc_re_d;
    acc_im_q   <= acc_im_d;
    sq_q       <= sq_d;
    fin_it_q   <= fin_it_d;
    fin_conv_q <= fin_conv_d;
    fin_idx_q  <= fin_idx_d;
    res_it_q   <= res_it_d;
    res_conv_q <= res_conv_d;
    res_idx_q  <= res_idx_d;
  end

  assign out_valid_o  = out_valid_q;
  assign iterations_o = res_it_q;
  assign converged_o  = res_conv_q;
  assign root_index_o = res_idx_q;

  // no root means index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converged_o |-> root_index_o == 2'd0)
    else $error("root index set without convergence");

  // a match is always inside the step limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> iterations_o < step_limit_q)
    else $error("match index beyond step limit");

  // an accepted point makes the core busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core still ready after taking a point");

  // the divider only reports while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == nrb_pkg::S_DIV)
    else $error("divider result outside divide phase");

endmodule

[rtl/core/nrb_mul.sv]
module nrb_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/nrb_div.sv]
module nrb_div #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  num_i,
  input  logic        [63:0]  den_i,
  output nrb_pkg::div_stat_t  stat_o,
  output nrb_pkg::q_t         quot_o
);

  localparam int unsigned SH = 31 - FRAC_BITS;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        ov_q, ov_d;
  logic        neg_q, neg_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [30:0] lo_q, lo_d;
  logic [30:0] quo_q, quo_d;
  logic [63:0] mag;
  logic [79:0] lim;
  logic [63:0] trial;
  logic        ge;

  always_comb begin
    mag    = num_i[63] ? 64'(-num_i) : 64'(num_i);
    lim    = {16'd0, den_i} << SH;
    trial  = {rem_q[62:0], lo_q[30]};
    ge     = trial >= den_i;
    busy_d = busy_q;
    done_d = 1'b0;
    ov_d   = ov_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    if (start_i) begin
      neg_d = num_i[63];
      quo_d = '0;
      cnt_d = '0;
      // quotient of 2^31 or more cannot be represented
      if ({16'd0, mag} >= lim) begin
        done_d = 1'b1;
        ov_d   = 1'b1;
      end else begin
        ov_d   = 1'b0;
        busy_d = 1'b1;
        rem_d  = mag >> SH;
        lo_d   = 31'(mag << FRAC_BITS);
      end
    end else if (busy_q) begin
      rem_d = ge ? trial - den_i : trial;
      quo_d = {quo_q[29:0], ge};
      lo_d  = {lo_q[29:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(nrb_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ov_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ov_q   <= ov_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.ov   = ov_q;
  assign quot_o      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

[test/newton_root_basin_iterator_core_tb.sv]
`timescale 1ns / 100ps

module newton_root_basin_iterator_core_tb;

  localparam int    FRAC_W   = 28;
  localparam longint NEAR_LIM = 2684;
  localparam longint QMAXV    = 64'sd2147483647;
  localparam longint QMINV    = -64'sd2147483648;

  // one result beat, as seen on the output ports
  typedef struct packed {
    logic [15:0] iters;
    logic        conv;
    logic [1:0]  ridx;
  } basin_t;

  typedef struct {
    longint re;
    longint im;
  } zval_t;

  // directed plan: either a register write or a start point
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [31:0] sr;
    logic [31:0] si;
    bit          typed;
    basin_t      want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] start_real_i;
  logic [31:0] start_imag_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] iterations_o;
  logic        converged_o;
  logic [1:0]  root_index_o;

  // shadow copy of the register file
  logic [63:0] sh_coef [4];
  logic [63:0] sh_root [3];
  logic [15:0] sh_step_limit;

  basin_t    basin_q [$];
  plan_row_t plan [$];
  int        mismatches;
  int        tx_idle_pct;
  int        rx_stall_pct;
  bit        sat_hit;

  newton_root_basin_iterator_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_real_i (start_real_i),
    .start_imag_i (start_imag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .iterations_o (iterations_o),
    .converged_o  (converged_o),
    .root_index_o (root_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // fixed-point newton predictor
  // ---------------------------------------------------------------------

  function automatic longint sgn32(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // clamp to 32 bits, flag any clipping
  function automatic longint clip32(input longint v);
    if (v > QMAXV) begin
      sat_hit = 1'b1;
      return QMAXV;
    end
    if (v < QMINV) begin
      sat_hit = 1'b1;
      return QMINV;
    end
    return v;
  endfunction

  function automatic zval_t unpack_z(input logic [63:0] v);
    zval_t z;
    z.re = sgn32(v[63:32]);
    z.im = sgn32(v[31:0]);
    return z;
  endfunction

  // complex multiply-add, each partial product floored on its own
  function automatic zval_t zmac(input zval_t a, input zval_t b, input zval_t c);
    zval_t r;
    r.re = clip32(((a.re * b.re) >>> FRAC_W) - ((a.im * b.im) >>> FRAC_W));
    r.im = clip32(((a.re * b.im) >>> FRAC_W) + ((a.im * b.re) >>> FRAC_W));
    r.re = clip32(r.re + c.re);
    r.im = clip32(r.im + c.im);
    return r;
  endfunction

  // long division, FRAC_W fraction bits, truncated toward zero
  function automatic longint frac_div(input longint num, input longint den);
    bit              neg;
    longint unsigned m;
    longint unsigned d;
    longint unsigned q;
    longint unsigned r;
    neg = num < 0;
    m   = neg ? longint'(-num) : num;
    d   = den;
    q   = m / d;
    r   = m % d;
    if (q > 64'h7FFF_FFFF) begin
      sat_hit = 1'b1;
      return 0;
    end
    for (int i = 0; i < FRAC_W; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q > 64'h7FFF_FFFF) begin
        sat_hit = 1'b1;
        return 0;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit is_near(input zval_t z, input zval_t rt);
    longint          dr;
    longint          di;
    longint unsigned mr;
    longint unsigned mi;
    dr = z.re - rt.re;
    di = z.im - rt.im;
    mr = dr < 0 ? longint'(-dr) : dr;
    mi = di < 0 ? longint'(-di) : di;
    // a component off by 2^31 or more never counts as near
    if (mr >= 64'h8000_0000 || mi >= 64'h8000_0000) return 1'b0;
    return ((mr * mr + mi * mi) >> FRAC_W) < NEAR_LIM;
  endfunction

  function automatic basin_t predict_basin(input logic [31:0] sr, input logic [31:0] si);
    basin_t res;
    zval_t  c0, c1, c2, c3, d2, d1, z, p, d, rt;
    longint den, nre, nim, qre, qim;
    c0 = unpack_z(sh_coef[0]);
    c1 = unpack_z(sh_coef[1]);
    c2 = unpack_z(sh_coef[2]);
    c3 = unpack_z(sh_coef[3]);
    res.iters = sh_step_limit;
    res.conv  = 1'b0;
    res.ridx  = 2'd0;
    sat_hit   = 1'b0;
    // derivative coefficients 3*c3 and 2*c2
    d2.re = clip32(3 * c3.re);
    d2.im = clip32(3 * c3.im);
    d1.re = clip32(2 * c2.re);
    d1.im = clip32(2 * c2.im);
    if (sat_hit) return res;
    z.re = sgn32(sr);
    z.im = sgn32(si);
    for (int it = 0; it < int'(sh_step_limit); it++) begin
      p = zmac(zmac(zmac(c3, z, c2), z, c1), z, c0);
      d = zmac(zmac(d2, z, d1), z, c1);
      if (sat_hit) return res;
      den = ((d.re * d.re) >>> 2) + ((d.im * d.im) >>> 2);
      if (den <= 0) return res;
      nre = ((p.re * d.re) >>> 2) + ((p.im * d.im) >>> 2);
      nim = ((p.im * d.re) >>> 2) - ((p.re * d.im) >>> 2);
      qre = frac_div(nre, den);
      qim = frac_div(nim, den);
      if (sat_hit) return res;
      z.re = clip32(z.re - qre);
      z.im = clip32(z.im - qim);
      if (sat_hit) return res;
      for (int k = 0; k < 3; k++) begin
        rt = unpack_z(sh_root[k]);
        if (is_near(z, rt)) begin
          res.iters = it[15:0];
          res.conv  = 1'b1;
          res.ridx  = k[1:0];
          return res;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [31:0] to_q(input real x);
    return 32'($rtoi(x * 268435456.0));
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_pt(input logic [31:0] sr, input logic [31:0] si);
    plan_row_t r;
    r = '{default: '0};
    r.sr = sr;
    r.si = si;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_pt_want(input logic [31:0] sr, input logic [31:0] si,
                                      input logic [15:0] it, input logic cv,
                                      input logic [1:0] k);
    plan_row_t r;
    r = '{default: '0};
    r.sr    = sr;
    r.si    = si;
    r.typed = 1'b1;
    r.want  = '{iters: it, conv: cv, ridx: k};
    plan.insert(plan.size(), r);
  endfunction

  // register write, only once every result is back
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    while (basin_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < nrb_pkg::REG_ROOT_A) sh_coef[idx] = data;
    else if (idx < nrb_pkg::REG_STEP_LIMIT) sh_root[idx - nrb_pkg::REG_ROOT_A] = data;
    else sh_step_limit = data[15:0];
  endtask

  // one start point beat; expectation goes in on acceptance
  task automatic send_point(input logic [31:0] sr, input logic [31:0] si,
                            input bit typed, input basin_t want);
    while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    @(posedge clk_i);
    in_valid_i   <= 1'b1;
    start_real_i <= sr;
    start_imag_i <= si;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    basin_q.insert(basin_q.size(), typed ? want : predict_basin(sr, si));
  endtask

  // ---------------------------------------------------------------------
  // output side: random stall and compare against the oldest expectation
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    basin_t got;
    basin_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{iters: iterations_o, conv: converged_o, ridx: root_index_o};
      if (basin_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_b = basin_q.pop_front();
        if (got.iters !== exp_b.iters || got.conv !== exp_b.conv ||
            got.ridx !== exp_b.ridx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: iterations %0d/%0d converged %0d/%0d root %0d/%0d (exp/act)",
                     exp_b.iters, got.iters, exp_b.conv, got.conv, exp_b.ridx, got.ridx);
        end
      end
    end
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    real         rr [3];
    real         ri [3];
    real         pr, pi, c2r, c2i, c1r, c1i, c0r, c0i;
    logic [31:0] sr, si;
    logic [63:0] rt [3];
    basin_t      none;

    none          = '0;
    mismatches    = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = nrb_pkg::REG_COEF_0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    start_real_i  = '0;
    start_imag_i  = '0;
    sh_coef[0]    = nrb_pkg::COEF_0_RST;
    sh_coef[1]    = '0;
    sh_coef[2]    = '0;
    sh_coef[3]    = nrb_pkg::COEF_3_RST;
    sh_root[0]    = '0;
    sh_root[1]    = '0;
    sh_root[2]    = '0;
    sh_step_limit = nrb_pkg::STEP_LIMIT_RST;

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed plan, starting from reset values (p = z^3 - 1, roots all 0)
    add_pt_want(32'h0, 32'h0, 16'd30, 1'b0, 2'd0);   // zero derivative at origin
    add_pt(32'h7FFF_FFFF, 32'h8000_0000);             // field extremes
    add_pt(32'h8000_0000, 32'h7FFF_FFFF);
    add_pt(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // cube roots of unity
    add_cfg(nrb_pkg::REG_ROOT_A, 64'h1000_0000_0000_0000);
    add_cfg(nrb_pkg::REG_ROOT_B, {to_q(-0.5), to_q(0.8660254)});
    add_cfg(nrb_pkg::REG_ROOT_C, {to_q(-0.5), to_q(-0.8660254)});
    add_pt_want(32'h1000_0000, 32'h0, 16'd0, 1'b1, 2'd0);  // exactly on root a
    add_pt(32'hF000_0000, 32'h0);
    add_pt(32'h0, 32'h1000_0000);
    add_pt(32'h0800_0000, 32'hF800_0000);
    // only root b matches, then only root c
    add_cfg(nrb_pkg::REG_ROOT_A, 64'h7000_0000_7000_0000);
    add_cfg(nrb_pkg::REG_ROOT_B, 64'h1000_0000_0000_0000);
    add_pt_want(32'h1000_0000, 32'h0, 16'd0, 1'b1, 2'd1);
    add_cfg(nrb_pkg::REG_ROOT_B, 64'h7000_0000_7000_0000);
    add_cfg(nrb_pkg::REG_ROOT_C, 64'h1000_0000_0000_0000);
    add_pt_want(32'h1000_0000, 32'h0, 16'd0, 1'b1, 2'd2);
    // duplicate roots: a wins over c
    add_cfg(nrb_pkg::REG_ROOT_A, 64'h1000_0000_0000_0000);
    add_pt_want(32'h1000_0000, 32'h0, 16'd0, 1'b1, 2'd0);
    // root at -8, point near +8: difference too far to be near
    add_cfg(nrb_pkg::REG_ROOT_A, 64'h8000_0000_0000_0000);
    add_pt(32'h7FFF_0000, 32'h0);
    // no step at all
    add_cfg(nrb_pkg::REG_STEP_LIMIT, 64'h0);
    add_pt_want(32'h1000_0000, 32'h0, 16'd0, 1'b0, 2'd0);
    // full limit, upper data bits ignored
    add_cfg(nrb_pkg::REG_STEP_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_pt_want(32'h0, 32'h0, 16'hFFFF, 1'b0, 2'd0);
    // 3*c3 and 2*c2 overflow
    add_cfg(nrb_pkg::REG_COEF_3, 64'h7FFF_FFFF_7FFF_FFFF);
    add_pt_want(32'h1000_0000, 32'h1000_0000, 16'hFFFF, 1'b0, 2'd0);
    add_cfg(nrb_pkg::REG_COEF_3, 64'h1000_0000_0000_0000);
    add_cfg(nrb_pkg::REG_COEF_2, 64'h8000_0000_8000_0000);
    add_pt_want(32'h1000_0000, 32'h1000_0000, 16'hFFFF, 1'b0, 2'd0);
    add_cfg(nrb_pkg::REG_COEF_2, 64'h0);
    add_cfg(nrb_pkg::REG_STEP_LIMIT, 64'd20);
    add_pt(32'h2000_0000, 32'h1800_0000);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_point(plan[i].sr, plan[i].si, plan[i].typed, plan[i].want);
    end

    // random phases: both sides idle at times (receiver more, then sender more), then neither
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = (ph == 0) ? 24 : (ph == 1) ? 54 : 0;
      rx_stall_pct = (ph == 0) ? 54 : (ph == 1) ? 24 : 0;

      // a cubic with known roots, real and imaginary parts within +-1
      for (int k = 0; k < 3; k++) begin
        rr[k] = ($itor($urandom_range(0, 32'h2000_0000)) - 268435456.0) / 268435456.0;
        ri[k] = ($itor($urandom_range(0, 32'h2000_0000)) - 268435456.0) / 268435456.0;
        rt[k] = {to_q(rr[k]), to_q(ri[k])};
      end
      pr  = rr[0] * rr[1] - ri[0] * ri[1];
      pi  = rr[0] * ri[1] + ri[0] * rr[1];
      c2r = -(rr[0] + rr[1] + rr[2]);
      c2i = -(ri[0] + ri[1] + ri[2]);
      c1r = pr + (rr[0] * rr[2] - ri[0] * ri[2]) + (rr[1] * rr[2] - ri[1] * ri[2]);
      c1i = pi + (rr[0] * ri[2] + ri[0] * rr[2]) + (rr[1] * ri[2] + ri[1] * rr[2]);
      c0r = -(pr * rr[2] - pi * ri[2]);
      c0i = -(pr * ri[2] + pi * rr[2]);
      // sometimes one root register holds junk
      if ($urandom_range(2) == 0) rt[$urandom_range(2)] = {$urandom, $urandom};
      write_reg(nrb_pkg::REG_COEF_0, {to_q(c0r), to_q(c0i)});
      write_reg(nrb_pkg::REG_COEF_1, {to_q(c1r), to_q(c1i)});
      write_reg(nrb_pkg::REG_COEF_2, {to_q(c2r), to_q(c2i)});
      write_reg(nrb_pkg::REG_COEF_3, 64'h1000_0000_0000_0000);
      write_reg(nrb_pkg::REG_ROOT_A, rt[0]);
      write_reg(nrb_pkg::REG_ROOT_B, rt[1]);
      write_reg(nrb_pkg::REG_ROOT_C, rt[2]);
      write_reg(nrb_pkg::REG_STEP_LIMIT, 64'($urandom_range(12, 40)));

      for (int n = 0; n < 133; n++) begin
        if ($urandom_range(99) < 85) begin
          // start points within +-2
          sr = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
          si = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end else begin
          sr = $urandom;
          si = $urandom;
        end
        // hold off now and then until the pipe is empty
        if ($urandom_range(49) == 0)
          while (basin_q.size() != 0) @(posedge clk_i);
        send_point(sr, si, 1'b0, none);
      end
    end

    while (basin_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && basin_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
